>>> design/dhte_pkg.sv
// shared types and constants for the double hashing table engine
// no dependencies; imported by every module of the block
package dhte_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] MODULUS_RST = 9'd256;
  localparam logic [CFG_DATA_W-1:0] STEP_RST    = 9'd7;
  localparam logic [CFG_DATA_W-1:0] LIMIT_RST   = 9'd256;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DELETED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FOUND     = 3'd4;

  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_USED    = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [30:0] key;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] slot_index;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV_KEY,
    S_LD_STEP,
    S_DIV_STEP,
    S_PROBE_INIT,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       clr_step;
    logic       accept;
    logic       shift;
    logic       ld_step;
    logic       set_stepm;
    logic       rd_en;
    logic       advance;
    logic       wr_en;
    logic [1:0] wr_mark;
    logic       res_load;
    logic [2:0] res_status;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       shift_last;
    logic [1:0] op;
    logic [1:0] mark;
    logic       key_match;
    logic       probe_last;
    logic       out_free;
  } dp_stat_t;

endpackage

>>> design/dhte_ctrl.sv
// controller state machine for the double hashing table engine
// depends on dhte_pkg; drives dhte_dp through command and status structs
module dhte_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dhte_pkg::dp_stat_t st,
  output dhte_pkg::dp_cmd_t  cmd
);
  import dhte_pkg::*;

  state_t state_r, state_nxt;
  logic   is_insert, hit, stop_empty;

  assign is_insert  = (st.op == OP_INSERT);
  assign hit        = is_insert ? (st.mark != MARK_USED)
                                : ((st.mark == MARK_USED) && st.key_match);
  assign stop_empty = !is_insert && (st.mark == MARK_EMPTY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_DIV_KEY;
      end
      S_DIV_KEY: begin
        if (st.op == OP_NONE) state_nxt = S_DONE;
        else if (st.shift_last) state_nxt = S_LD_STEP;
      end
      S_LD_STEP:    state_nxt = S_DIV_STEP;
      S_DIV_STEP: begin
        if (st.shift_last) state_nxt = S_PROBE_INIT;
      end
      S_PROBE_INIT: state_nxt = S_READ;
      S_READ:       state_nxt = S_CHECK;
      S_CHECK: begin
        if (hit || stop_empty || st.probe_last) state_nxt = S_DONE;
        else state_nxt = S_READ;
      end
      S_DONE: begin
        if (st.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != S_IDLE);
    unique case (state_r)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE:  cmd.accept = in_valid;
      S_DIV_KEY: begin
        if (st.op == OP_NONE) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_LD_STEP:    cmd.ld_step = 1'b1;
      S_DIV_STEP:   cmd.shift = 1'b1;
      S_PROBE_INIT: cmd.set_stepm = 1'b1;
      S_READ:       cmd.rd_en = 1'b1;
      S_CHECK: begin
        if (hit) begin
          cmd.res_load = 1'b1;
          case (st.op)
            OP_INSERT: begin
              cmd.wr_en      = 1'b1;
              cmd.wr_mark    = MARK_USED;
              cmd.res_status = ST_INSERTED;
            end
            OP_DELETE: begin
              cmd.wr_en      = 1'b1;
              cmd.wr_mark    = MARK_DELETED;
              cmd.res_status = ST_DELETED;
            end
            default: cmd.res_status = ST_FOUND;
          endcase
        end else if (stop_empty || st.probe_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = is_insert ? ST_FULL : ST_NOT_FOUND;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_DONE:  cmd.out_load = st.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

>>> design/dhte_dp.sv
// datapath: config registers, serial remainder lanes, probe position, slot memory
// and the output register; depends on dhte_pkg, commanded by dhte_ctrl
module dhte_dp #(
  parameter int SLOTS    = 256,
  parameter int KEY_BITS = 31
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dhte_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dhte_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  dhte_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dhte_pkg::out_item_t                 out_item,
  input  dhte_pkg::dp_cmd_t                   cmd,
  output dhte_pkg::dp_stat_t                  st
);
  import dhte_pkg::*;

  localparam int KEY_W = (KEY_BITS < 31) ? KEY_BITS : 31;
  localparam int DVD_W = (KEY_W > 9) ? KEY_W : 9;
  localparam int CNT_W = $clog2(DVD_W);
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CLR_N = (SLOTS < 512) ? SLOTS : 512;
  localparam int CLR_W = $clog2(CLR_N);
  localparam int ENT_W = 2 + KEY_W;

  // config registers and their effective values
  logic [8:0] mod_r, base_r, lim_r;
  logic [8:0] m_eff, b_eff, lim_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r  <= MODULUS_RST;
      base_r <= STEP_RST;
      lim_r  <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODULUS: mod_r  <= cfg_data;
        CFG_STEP:    base_r <= cfg_data;
        CFG_LIMIT:   lim_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (mod_r == '0) m_eff = 9'd1;
    else if (32'(mod_r) > SLOTS) m_eff = 9'(SLOTS);
    else m_eff = mod_r;
    b_eff   = (base_r == '0) ? 9'd1 : base_r;
    lim_eff = (lim_r == '0) ? 9'd1 : lim_r;
  end

  // item registers
  logic [1:0]       op_r;
  logic [KEY_W-1:0] key_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_item.op;
      key_r <= in_item.key[KEY_W-1:0];
    end
  end

  // two remainder lanes, one dividend bit per cycle
  logic [DVD_W-1:0] dvd_r;
  logic [8:0]       rem_a_r, rem_b_r, rem_a_nxt, rem_b_nxt;
  logic [9:0]       ta, tb;
  logic [CNT_W-1:0] cnt_r;
  logic [8:0]       step_val;

  assign ta        = {rem_a_r, dvd_r[DVD_W-1]};
  assign tb        = {rem_b_r, dvd_r[DVD_W-1]};
  assign rem_a_nxt = (ta >= {1'b0, m_eff}) ? 9'(ta - {1'b0, m_eff}) : ta[8:0];
  assign rem_b_nxt = (tb >= {1'b0, b_eff}) ? 9'(tb - {1'b0, b_eff}) : tb[8:0];
  assign step_val  = b_eff - rem_b_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dvd_r   <= DVD_W'(in_item.key[KEY_W-1:0]);
      rem_a_r <= '0;
      rem_b_r <= '0;
      cnt_r   <= CNT_W'(DVD_W - 1);
    end else if (cmd.ld_step) begin
      dvd_r   <= DVD_W'(step_val);
      rem_a_r <= '0;
      rem_b_r <= '0;
      cnt_r   <= CNT_W'(DVD_W - 1);
    end else if (cmd.shift) begin
      dvd_r   <= dvd_r << 1;
      rem_a_r <= rem_a_nxt;
      rem_b_r <= rem_b_nxt;
      cnt_r   <= cnt_r - 1'b1;
    end
  end

  // probe position: pos advances by step mod m with one compare and subtract
  logic [8:0] pos_r, stepm_r, n_r;
  logic [9:0] pos_sum;

  assign pos_sum = {1'b0, pos_r} + {1'b0, stepm_r};

  always_ff @(posedge clk) begin
    if (cmd.ld_step) begin
      pos_r <= rem_a_r;
    end else if (cmd.advance) begin
      pos_r <= (pos_sum >= {1'b0, m_eff}) ? 9'(pos_sum - {1'b0, m_eff}) : pos_sum[8:0];
    end
    if (cmd.set_stepm) begin
      stepm_r <= rem_a_r;
    end
    if (cmd.set_stepm) begin
      n_r <= '0;
    end else if (cmd.advance) begin
      n_r <= n_r + 1'b1;
    end
  end

  // slot memory: mark in the top two bits, key below
  logic [ENT_W-1:0] slot_mem_r [SLOTS];
  logic [ENT_W-1:0] q_r;
  logic [CLR_W-1:0] clr_r;
  logic [IDX_W-1:0] pos_addr, wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic [KEY_W-1:0] q_key;
  logic [1:0]       q_mark;

  assign pos_addr = IDX_W'(pos_r);
  assign q_key    = q_r[KEY_W-1:0];
  assign q_mark   = q_r[ENT_W-1 -: 2];

  always_comb begin
    if (cmd.clr_step) begin
      wr_addr = IDX_W'(clr_r);
      wr_data = {MARK_EMPTY, {KEY_W{1'b0}}};
    end else begin
      wr_addr = pos_addr;
      // a delete keeps the stored key, an insert writes the new one
      wr_data = {cmd.wr_mark, (cmd.wr_mark == MARK_USED) ? key_r : q_key};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step || cmd.wr_en) begin
      slot_mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      q_r <= slot_mem_r[pos_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  // result and output register
  out_item_t res_r, out_r;
  logic      out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_r.status     <= cmd.res_status;
      res_r.slot_index <= (cmd.res_status == ST_FULL || cmd.res_status == ST_NOT_FOUND)
                          ? 8'd0 : pos_r[7:0];
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    st.clr_last   = (clr_r == CLR_W'(CLR_N - 1));
    st.shift_last = (cnt_r == '0);
    st.op         = op_r;
    st.mark       = q_mark;
    st.key_match  = (q_key == key_r);
    st.probe_last = (n_r == lim_eff - 9'd1);
    st.out_free   = !out_valid_r || !out_stall;
  end

endmodule

>>> design/double_hash_table_engine.sv
// top level of the double hashing table engine: controller plus datapath
// depends on dhte_pkg, dhte_ctrl and dhte_dp
//
//   channel   ports                         moves
//   in        in_valid in_stall in_item     one operation (op, key) per beat
//   out       out_valid out_stall out_item  one result (status, slot_index) per beat
//   cfg       cfg_we cfg_index cfg_data     register write, no read-back
//
// an item first runs two serial remainder passes and then probes the slot memory:
// key mod m and key mod b in the first pass, then step mod m in the second;
// each probe has a read state and a check state; the unused op code skips the passes and probes
// after reset a clearing pass writes min(SLOTS,512) slots as empty, one per cycle, in_stall high
// a result waits in the output register while the next item is taken; if it is still
// stalled when the following result is ready, the engine holds that result and stalls input
module double_hash_table_engine #(
  parameter int SLOTS    = 256,
  parameter int KEY_BITS = 31
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dhte_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dhte_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [dhte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dhte_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dhte_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  dhte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  dhte_dp #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
